// File: rtl/core/mbdc_pkg.sv
// Shared types and constants for the masked byte difference clusterer.
package mbdc_pkg;

  localparam int OFFSET_BITS  = 24;  // width of the byte position counter
  localparam int OFFSET_W     = 24;  // width of the run offset field
  localparam int CNT_W        = 25;  // width of byte counters and run length
  localparam int RUNS_W       = 24;  // width of the run counter
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_IDENTICAL = 2'd0,
    OUTCOME_GAPS_ONLY = 2'd1,
    OUTCOME_TEXT_ONLY = 2'd2,
    OUTCOME_MIXED     = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [7:0] new_byte;
    logic [7:0] ref_byte;
    logic       adcon_new;
    logic       adcon_ref;
    logic       skip_byte;
    logic       text_written;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic                record_kind;
    logic [OFFSET_W-1:0] run_offset;
    logic [CNT_W-1:0]    run_length;
    logic                run_gap;
    logic [CNT_W-1:0]    mismatch_total;
    logic [CNT_W-1:0]    text_mismatch;
    logic [CNT_W-1:0]    gap_mismatch;
    logic [CNT_W-1:0]    adcon_cleared;
    logic [CNT_W-1:0]    skipped_total;
    logic [RUNS_W-1:0]   run_total;
    outcome_t            outcome;
    logic                final_record;
  } rec_t;

  // Records produced by one byte pair, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } rec_pair_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    sat_cnt = (&v) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [RUNS_W-1:0] sat_runs(input logic [RUNS_W-1:0] v);
    sat_runs = (&v) ? v : v + RUNS_W'(1);
  endfunction

endpackage

// File: rtl/core/mbdc_engine.sv
// Section state, byte pair classification and record generation.
module mbdc_engine
  import mbdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  item_t     item,
  input  logic      clear_adcons,
  output rec_pair_t recs
);

  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic                   run_open, run_open_next;
  logic [OFFSET_BITS-1:0] run_begin, run_begin_next;
  logic [CNT_W-1:0]       run_size, run_size_next;
  logic                   run_gap_flag, run_gap_flag_next;
  logic [CNT_W-1:0]       count_mismatch, count_mismatch_next;
  logic [CNT_W-1:0]       count_text, count_text_next;
  logic [CNT_W-1:0]       count_gap, count_gap_next;
  logic [CNT_W-1:0]       count_adcon, count_adcon_next;
  logic [CNT_W-1:0]       count_skipped, count_skipped_next;
  logic [RUNS_W-1:0]      count_runs, count_runs_next;

  always_comb begin
    logic     is_adcon;
    logic     is_skip;
    logic     is_diff;
    logic     run_emit;
    rec_t     run_rec;
    rec_t     sum_rec;
    outcome_t verdict;

    is_adcon = clear_adcons && (item.adcon_new || item.adcon_ref);
    is_skip  = !is_adcon && item.skip_byte;
    is_diff  = !is_adcon && !is_skip && (item.new_byte != item.ref_byte);

    byte_position_next  = byte_position + OFFSET_BITS'(1);
    run_open_next       = run_open;
    run_begin_next      = run_begin;
    run_size_next       = run_size;
    run_gap_flag_next   = run_gap_flag;
    count_mismatch_next = count_mismatch;
    count_text_next     = count_text;
    count_gap_next      = count_gap;
    count_adcon_next    = is_adcon ? sat_cnt(count_adcon) : count_adcon;
    count_skipped_next  = is_skip ? sat_cnt(count_skipped) : count_skipped;
    count_runs_next     = count_runs;

    if (is_diff) begin
      count_mismatch_next = sat_cnt(count_mismatch);
      if (item.text_written) begin
        count_text_next = sat_cnt(count_text);
      end else begin
        count_gap_next = sat_cnt(count_gap);
      end
      if (!run_open) begin
        run_open_next     = 1'b1;
        run_begin_next    = byte_position;
        run_size_next     = CNT_W'(1);
        run_gap_flag_next = !item.text_written;
        count_runs_next   = sat_runs(count_runs);
      end else begin
        run_size_next = sat_cnt(run_size);
      end
    end

    // A run closes on any byte that does not differ, and at the section end.
    run_emit = run_open_next && (!is_diff || item.final_byte);

    run_rec             = '0;
    run_rec.record_kind = KIND_RUN;
    run_rec.run_offset  = OFFSET_W'(run_begin_next);
    run_rec.run_length  = run_size_next;
    run_rec.run_gap     = run_gap_flag_next;
    run_rec.outcome     = OUTCOME_IDENTICAL;

    if (count_mismatch_next == '0) begin
      verdict = OUTCOME_IDENTICAL;
    end else if (count_text_next == '0) begin
      verdict = OUTCOME_GAPS_ONLY;
    end else if (count_gap_next == '0) begin
      verdict = OUTCOME_TEXT_ONLY;
    end else begin
      verdict = OUTCOME_MIXED;
    end

    sum_rec                = '0;
    sum_rec.record_kind    = KIND_SUMMARY;
    sum_rec.mismatch_total = count_mismatch_next;
    sum_rec.text_mismatch  = count_text_next;
    sum_rec.gap_mismatch   = count_gap_next;
    sum_rec.adcon_cleared  = count_adcon_next;
    sum_rec.skipped_total  = count_skipped_next;
    sum_rec.run_total      = count_runs_next;
    sum_rec.outcome        = verdict;
    sum_rec.final_record   = 1'b1;

    if (run_emit) begin
      run_open_next = 1'b0;
      run_size_next = '0;
    end

    recs.first  = run_emit ? run_rec : sum_rec;
    recs.second = sum_rec;
    recs.count  = {1'b0, run_emit} + {1'b0, item.final_byte};

    if (item.final_byte) begin
      byte_position_next  = '0;
      run_open_next       = 1'b0;
      run_begin_next      = '0;
      run_size_next       = '0;
      run_gap_flag_next   = 1'b0;
      count_mismatch_next = '0;
      count_text_next     = '0;
      count_gap_next      = '0;
      count_adcon_next    = '0;
      count_skipped_next  = '0;
      count_runs_next     = '0;
    end

    if (!step) begin
      recs.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      run_open       <= 1'b0;
      run_begin      <= '0;
      run_size       <= '0;
      run_gap_flag   <= 1'b0;
      count_mismatch <= '0;
      count_text     <= '0;
      count_gap      <= '0;
      count_adcon    <= '0;
      count_skipped  <= '0;
      count_runs     <= '0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      run_open       <= run_open_next;
      run_begin      <= run_begin_next;
      run_size       <= run_size_next;
      run_gap_flag   <= run_gap_flag_next;
      count_mismatch <= count_mismatch_next;
      count_text     <= count_text_next;
      count_gap      <= count_gap_next;
      count_adcon    <= count_adcon_next;
      count_skipped  <= count_skipped_next;
      count_runs     <= count_runs_next;
    end
  end

endmodule

// File: rtl/core/mbdc_rec_fifo.sv
// Small record queue that takes up to two records per cycle and gives one while rd_ready is high.
module mbdc_rec_fifo
  import mbdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rec_pair_t push,
  output logic      room_for_two,
  output logic      rd_valid,
  input  logic      rd_ready,
  output rec_t      rd_data
);

  rec_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_CNT_W-1:0] fill, fill_next;
  logic                  pop;

  assign rd_valid     = (fill != '0);
  assign rd_data      = mem[rd_ptr];
  assign pop          = rd_valid && rd_ready;
  assign room_for_two = (fill <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_PTR_W'(push.count);
    rd_ptr_next = rd_ptr + FIFO_PTR_W'(pop);
    fill_next   = fill + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

endmodule

// File: rtl/core/masked_byte_diff_clusterer.sv
// Top level of the masked byte difference clusterer.
// An accepted byte pair waits in the input stage register until the queue has two
// free slots; it is then folded into the section state and its records enter the queue.
// Throughput: one byte pair per cycle. A final byte can yield two records; they drain
// one per cycle while out_ready is high, and input stalls while the four-entry queue lacks two free slots.
// Reset (rst, synchronous) clears the section state and the queue; clear_adcons goes to 1.
module masked_byte_diff_clusterer
  import mbdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  // Configuration: the clear_adcons register.
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,

  // Byte pair input transaction.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          new_byte,
  input  logic [7:0]          ref_byte,
  input  logic                adcon_new,
  input  logic                adcon_ref,
  input  logic                skip_byte,
  input  logic                text_written,
  input  logic                final_byte,

  // Result record output transaction.
  output logic                out_valid,
  input  logic                out_ready,
  output logic                record_kind,
  output logic [OFFSET_W-1:0] run_offset,
  output logic [CNT_W-1:0]    run_length,
  output logic                run_gap,
  output logic [CNT_W-1:0]    mismatch_total,
  output logic [CNT_W-1:0]    text_mismatch,
  output logic [CNT_W-1:0]    gap_mismatch,
  output logic [CNT_W-1:0]    adcon_cleared,
  output logic [CNT_W-1:0]    skipped_total,
  output logic [RUNS_W-1:0]   run_total,
  output logic [1:0]          outcome,
  output logic                final_record
);

  logic      clear_adcons;
  logic      stage_valid;
  item_t     stage_item;
  logic      stage_fire;
  logic      room_for_two;
  rec_pair_t recs;
  rec_t      head;

  // The configuration register is written directly; there is no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_adcons <= 1'b1;
    end else if (cfg_wr_en) begin
      clear_adcons <= cfg_wr_data;
    end
  end

  // The staged byte pair is processed whenever the queue can absorb the worst
  // case of two records, so the engine never has to stall in mid-step.
  assign stage_fire = stage_valid && room_for_two;
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.new_byte     <= new_byte;
      stage_item.ref_byte     <= ref_byte;
      stage_item.adcon_new    <= adcon_new;
      stage_item.adcon_ref    <= adcon_ref;
      stage_item.skip_byte    <= skip_byte;
      stage_item.text_written <= text_written;
      stage_item.final_byte   <= final_byte;
    end
  end

  // Classification, counters, run tracking and record building.
  mbdc_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (stage_fire),
    .item         (stage_item),
    .clear_adcons (clear_adcons),
    .recs         (recs)
  );

  // Records wait here until the output side takes them, in order.
  mbdc_rec_fifo u_rec_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (recs),
    .room_for_two (room_for_two),
    .rd_valid     (out_valid),
    .rd_ready     (out_ready),
    .rd_data      (head)
  );

  assign record_kind    = head.record_kind;
  assign run_offset     = head.run_offset;
  assign run_length     = head.run_length;
  assign run_gap        = head.run_gap;
  assign mismatch_total = head.mismatch_total;
  assign text_mismatch  = head.text_mismatch;
  assign gap_mismatch   = head.gap_mismatch;
  assign adcon_cleared  = head.adcon_cleared;
  assign skipped_total  = head.skipped_total;
  assign run_total      = head.run_total;
  assign outcome        = head.outcome;
  assign final_record   = head.final_record;

endmodule

// File: dv/mbdc_record_check.sv
// Record checker for the masked byte difference clusterer: predicts and compares result records.
module mbdc_record_check
  import mbdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          new_byte,
  input  logic [7:0]          ref_byte,
  input  logic                adcon_new,
  input  logic                adcon_ref,
  input  logic                skip_byte,
  input  logic                text_written,
  input  logic                final_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                record_kind,
  input  logic [OFFSET_W-1:0] run_offset,
  input  logic [CNT_W-1:0]    run_length,
  input  logic                run_gap,
  input  logic [CNT_W-1:0]    mismatch_total,
  input  logic [CNT_W-1:0]    text_mismatch,
  input  logic [CNT_W-1:0]    gap_mismatch,
  input  logic [CNT_W-1:0]    adcon_cleared,
  input  logic [CNT_W-1:0]    skipped_total,
  input  logic [RUNS_W-1:0]   run_total,
  input  logic [1:0]          outcome,
  input  logic                final_record,
  output int                  error_count,
  output int                  pending_recs
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted section state, mirrored from the accepted byte pairs.
  logic                   clear_adcon_en;
  logic [OFFSET_BITS-1:0] position;
  logic                   run_active;
  logic [OFFSET_W-1:0]    run_start;
  logic [CNT_W-1:0]       run_len;
  logic                   run_in_gap;
  logic [CNT_W-1:0]       diff_cnt;
  logic [CNT_W-1:0]       text_cnt;
  logic [CNT_W-1:0]       gap_cnt;
  logic [CNT_W-1:0]       adcon_cnt;
  logic [CNT_W-1:0]       skip_cnt;
  logic [RUNS_W-1:0]      runs_cnt;

  rec_t expected_recs[$];

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic clear_section();
    position   = '0;
    run_active = 1'b0;
    run_start  = '0;
    run_len    = '0;
    run_in_gap = 1'b0;
    diff_cnt   = '0;
    text_cnt   = '0;
    gap_cnt    = '0;
    adcon_cnt  = '0;
    skip_cnt   = '0;
    runs_cnt   = '0;
  endtask

  task automatic close_open_run();
    rec_t r;
    if (run_active) begin
      r            = '0;
      r.record_kind = KIND_RUN;
      r.run_offset = run_start;
      r.run_length = run_len;
      r.run_gap    = run_in_gap;
      expected_recs.push_back(r);
      run_active = 1'b0;
      run_len    = '0;
    end
  endtask

  task automatic push_summary();
    rec_t s;
    s                = '0;
    s.record_kind    = KIND_SUMMARY;
    s.mismatch_total = diff_cnt;
    s.text_mismatch  = text_cnt;
    s.gap_mismatch   = gap_cnt;
    s.adcon_cleared  = adcon_cnt;
    s.skipped_total  = skip_cnt;
    s.run_total      = runs_cnt;
    if (diff_cnt == '0) s.outcome = OUTCOME_IDENTICAL;
    else if (text_cnt == '0) s.outcome = OUTCOME_GAPS_ONLY;
    else if (gap_cnt == '0) s.outcome = OUTCOME_TEXT_ONLY;
    else s.outcome = OUTCOME_MIXED;
    s.final_record = 1'b1;
    expected_recs.push_back(s);
  endtask

  task automatic fold_pair();
    if (clear_adcon_en && (adcon_new || adcon_ref)) begin
      adcon_cnt = count_up(adcon_cnt);
      close_open_run();
    end else if (skip_byte) begin
      skip_cnt = count_up(skip_cnt);
      close_open_run();
    end else if (new_byte != ref_byte) begin
      diff_cnt = count_up(diff_cnt);
      if (text_written) text_cnt = count_up(text_cnt);
      else gap_cnt = count_up(gap_cnt);
      if (!run_active) begin
        run_active = 1'b1;
        run_start  = position;
        run_len    = '0;
        run_in_gap = !text_written;
        if (~&runs_cnt) runs_cnt = runs_cnt + 1'b1;
      end
      run_len = count_up(run_len);
    end else begin
      close_open_run();
    end
    position = position + 1'b1;
    if (final_byte) begin
      close_open_run();
      push_summary();
      clear_section();
    end
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_record();
    rec_t want;
    if (expected_recs.size() == 0) begin
      $error("record with no expectation: record_kind %0d run_offset %0d",
             record_kind, run_offset);
      error_count++;
    end else begin
      want = expected_recs.pop_front();
      compare_field("record_kind", want.record_kind, record_kind);
      compare_field("run_offset", want.run_offset, run_offset);
      compare_field("run_length", want.run_length, run_length);
      compare_field("run_gap", want.run_gap, run_gap);
      compare_field("mismatch_total", want.mismatch_total, mismatch_total);
      compare_field("text_mismatch", want.text_mismatch, text_mismatch);
      compare_field("gap_mismatch", want.gap_mismatch, gap_mismatch);
      compare_field("adcon_cleared", want.adcon_cleared, adcon_cleared);
      compare_field("skipped_total", want.skipped_total, skipped_total);
      compare_field("run_total", want.run_total, run_total);
      compare_field("outcome", want.outcome, outcome);
      compare_field("final_record", want.final_record, final_record);
    end
  endtask

  // Records are compared before the new pair is folded in; a record leaving at
  // this edge always belongs to an earlier pair.
  always @(posedge clk) begin
    if (rst) begin
      clear_adcon_en = 1'b1;
      clear_section();
      expected_recs.delete();
    end else begin
      if (out_valid && out_ready) check_record();
      if (cfg_wr_en) clear_adcon_en = cfg_wr_data;
      if (in_valid && in_ready) fold_pair();
    end
    pending_recs <= expected_recs.size();
  end

endmodule

// File: dv/tb_masked_byte_diff_clusterer.sv
// Testbench top for the masked byte difference clusterer: stimulus, idling and verdict.
module tb_masked_byte_diff_clusterer
  import mbdc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: about 1050 pairs with random gaps, up to two records per
  // section end, each waiting out random receiver stalls, plus the drains.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 257;
  localparam int SETTLE_WAIT  = 4;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          new_byte;
  logic [7:0]          ref_byte;
  logic                adcon_new;
  logic                adcon_ref;
  logic                skip_byte;
  logic                text_written;
  logic                final_byte;
  logic                out_valid;
  logic                out_ready;
  logic                record_kind;
  logic [OFFSET_W-1:0] run_offset;
  logic [CNT_W-1:0]    run_length;
  logic                run_gap;
  logic [CNT_W-1:0]    mismatch_total;
  logic [CNT_W-1:0]    text_mismatch;
  logic [CNT_W-1:0]    gap_mismatch;
  logic [CNT_W-1:0]    adcon_cleared;
  logic [CNT_W-1:0]    skipped_total;
  logic [RUNS_W-1:0]   run_total;
  logic [1:0]          outcome;
  logic                final_record;

  int   error_count;
  int   pending_recs;
  int   cycle_count;
  int   phase_items;
  bit   held_back;
  logic steady;

  masked_byte_diff_clusterer uut (.*);

  // The checker watches both channels and the register port beside the block.
  mbdc_record_check record_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost record ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_masked_byte_diff_clusterer: done, errors");
    $finish;
  end

  // The receiver stalls with a probability of roughly 17 percent, except while the steady
  // window is open, when it takes every record at once.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
  end

  // Offers one byte pair and returns at the edge where the transaction is
  // accepted. Valid is left high there, so the next call either replaces the
  // payload in the same step or drops valid for a gap; never both.
  task automatic push_pair(input logic [7:0] nb, input logic [7:0] rb, input logic an,
                           input logic ar, input logic sk, input logic tx,
                           input logic fin);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    new_byte     <= nb;
    ref_byte     <= rb;
    adcon_new    <= an;
    adcon_ref    <= ar;
    skip_byte    <= sk;
    text_written <= tx;
    final_byte   <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted record has come out, then lets
  // the pipeline run dry, since a pair that makes no record may still be in
  // flight when the last record arrives.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_recs != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic write_clear(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random section. Differences tend to follow differences so that runs of
  // several bytes form; address-constant and skip marks break them up, and the
  // byte values lean toward the extremes now and then.
  task automatic send_section(input int len);
    logic [7:0] nb;
    logic [7:0] rb;
    logic       an;
    logic       ar;
    logic       sk;
    logic       tx;
    bit         last_diff;
    int         pick;
    last_diff = 1'b0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) nb = 8'h00;
      else if (pick == 1) nb = 8'hFF;
      else nb = 8'($urandom_range(255));
      last_diff = ($urandom_range(99) < (last_diff ? 70 : 40));
      rb = last_diff ? nb ^ 8'($urandom_range(1, 255)) : nb;
      an = ($urandom_range(99) < 12);
      ar = ($urandom_range(99) < 12);
      sk = ($urandom_range(99) < 10);
      tx = ($urandom_range(99) < 70);
      push_pair(nb, rb, an, ar, sk, tx, i == len - 1);
      phase_items++;
    end
  endtask

  initial begin
    int len;
    int r;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    in_valid     <= 1'b0;
    new_byte     <= 8'h00;
    ref_byte     <= 8'h00;
    adcon_new    <= 1'b0;
    adcon_ref    <= 1'b0;
    skip_byte    <= 1'b0;
    text_written <= 1'b0;
    final_byte   <= 1'b0;
    steady       <= 1'b0;
    held_back    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with address-constant clearing at its reset value of 1.
    // A mixed section: a text-then-gap run closed by an equal byte, a gap run
    // closed by a skip mark, a run closed by a new-side address constant, then
    // a reference-side constant, a constant that outranks a skip mark, and a
    // difference on the final byte, so a run record precedes the summary.
    push_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_pair(8'h5A, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'h12, 8'h34, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_pair(8'hAA, 8'h55, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    push_pair(8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'h01, 8'h03, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'h77, 8'h77, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    push_pair(8'h80, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    push_pair(8'hFF, 8'hFE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // A one-byte identical section.
    push_pair(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    // Gaps only, with the run closed by a skip mark on the final byte.
    push_pair(8'h10, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_pair(8'h20, 8'h20, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    // Text only, a single differing final byte.
    push_pair(8'h3C, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    settle();

    // With clearing off, address-constant marks no longer hide differences.
    write_clear(1'b0);
    push_pair(8'h01, 8'h02, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    push_pair(8'h05, 8'h05, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    push_pair(8'h09, 8'h08, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    push_pair(8'h09, 8'h08, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    push_pair(8'h44, 8'h44, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);

    // Random part in four phases that alternate the clearing setting. Phase
    // two runs with no idling on either side; phase one holds the sender back
    // once midway until every record has drained.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_clear((phase % 2) == 0);
      steady      <= (phase == 2);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 5) len = 1;
        else if (r < 90) len = $urandom_range(2, 20);
        else len = $urandom_range(21, 64);
        send_section(len);
        if (phase == 1 && !held_back && phase_items >= PHASE_ITEMS / 2) begin
          settle();
          held_back = 1'b1;
        end
      end
    end

    // Drain everything still expected, then give the block time to show any
    // stray record before the verdict.
    steady <= 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_masked_byte_diff_clusterer: done, clean");
    end else begin
      $display("tb_masked_byte_diff_clusterer: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mbdc_pkg.sv
rtl/core/mbdc_engine.sv
rtl/core/mbdc_rec_fifo.sv
rtl/core/masked_byte_diff_clusterer.sv
dv/mbdc_record_check.sv
dv/tb_masked_byte_diff_clusterer.sv
